// ----- src/dlr_pkg.sv -----
// dlr_pkg: shared types and constants for the DDA line rasterizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package dlr_pkg;

  localparam int COORD_W = 6;
  localparam int COLOR_W = 4;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 4'd4;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
  } line_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] color;
    logic               last_pixel;
  } pixel_t;

endpackage

`default_nettype wire

// ----- src/dlr_divider.sv -----
// dlr_divider: restoring divider, one quotient bit per cycle.
// Computes (dividend << FRACTION_BITS) / divisor for dividend <= divisor.
// Depends on dlr_pkg.
`default_nettype none

module dlr_divider
  import dlr_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        load_i,
  input  wire  [COORD_W-1:0]         dividend_i,
  input  wire  [COORD_W-1:0]         divisor_i,
  output logic                       done_o,
  output logic [FRACTION_BITS:0]     quot_o
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRACTION_BITS);

  logic               run_q, run_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COORD_W:0]   rem_q, rem_d;
  logic [COORD_W-1:0] dsr_q, dsr_d;
  logic [FRACTION_BITS:0] q_q, q_d;
  logic               ge;
  logic [COORD_W:0]   rem_sub;

  // remainder stays below the divisor after each step, so rem << 1 fits
  assign ge      = (rem_q >= {1'b0, dsr_q});
  assign rem_sub = ge ? (rem_q - {1'b0, dsr_q}) : rem_q;
  assign quot_o  = {q_q[FRACTION_BITS-1:0], ge};
  assign done_o  = run_q && (cnt_q == CNT_LAST);

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    q_d   = q_q;
    if (load_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = {1'b0, dividend_i};
      dsr_d = divisor_i;
      q_d   = '0;
    end else if (run_q) begin
      rem_d = {rem_sub[COORD_W-1:0], 1'b0};
      q_d   = quot_o;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    q_q   <= q_d;
  end

endmodule

`default_nettype wire

// ----- src/dda_line_rasterizer.sv -----
// dda_line_rasterizer: DDA line rasterizer top level, sequencer and walk datapath.
// Depends on dlr_pkg and dlr_divider.
//
// Channel   Direction  Handshake                       Payload
// line      in         start & !busy                   line_i (line_t)
// pixel     out        pixel_strobe_o, one cycle only  pixel_o (pixel_t)
// cfg       in         cfg_valid_i & cfg_ready_o       cfg_data_i (pixel colour)
//
// Sequence: a zero-length line leaves busy low. Otherwise busy stays high while
// the shared bit-serial divider forms the x and then the y increment, one
// quotient bit per cycle, and while the walk then emits one pixel per cycle.
// Reset: asynchronous, active low; colour returns to 4, the sequencer to idle.
// The start pixel appears the cycle after the transaction; the receiver cannot
// stall, so every pixel is shown for exactly one cycle.
`default_nettype none

module dda_line_rasterizer
  import dlr_pkg::*;
#(
  parameter int TILE_SIZE     = 64,
  parameter int FRACTION_BITS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire  line_t        line_i,
  output logic               pixel_strobe_o,
  output pixel_t             pixel_o,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  [COLOR_W-1:0] cfg_data_i
);

  // Sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIVX = 2'd1;
  localparam logic [1:0] S_DIVY = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;

  // increment magnitude reaches 2^FB, plus a sign bit
  localparam int STEP_W = FRACTION_BITS + 2;
  // integer part, fraction and headroom for the sign
  localparam int ACC_W  = COORD_W + FRACTION_BITS + 2;
  localparam logic [COORD_W:0]   TILE_LIM = (COORD_W+1)'(TILE_SIZE);
  localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIZE - 1);

  logic [1:0]         state_q, state_d;
  logic [COLOR_W-1:0] color_q;
  logic               strobe_q, strobe_d;
  pixel_t             out_q, out_d;

  logic [COORD_W-1:0] steps_total_q, steps_total_d;
  logic [COORD_W-1:0] steps_done_q, steps_done_d;
  logic [COORD_W-1:0] ady_q, ady_d;
  logic               x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic [STEP_W-1:0]  x_step_q, x_step_d, y_step_q, y_step_d;
  logic [ACC_W-1:0]   x_acc_q, x_acc_d, y_acc_q, y_acc_d;

  logic               accept;
  logic [COORD_W-1:0] xs, ys, xe, ye, adx, ady, steps;
  logic [ACC_W-1:0]   x_sum, y_sum;
  logic [STEP_W-1:0]  quot_pos;
  logic [COORD_W-1:0] steps_next;

  logic               div_load, div_done;
  logic [COORD_W-1:0] div_dividend;
  logic [FRACTION_BITS:0] div_quot;

  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    r = ({1'b0, v} >= TILE_LIM) ? TILE_MAX : v;
    return r;
  endfunction

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;

  // Clamp into the tile, then per-axis distance and step count
  assign xs    = clamp(line_i.x_start);
  assign ys    = clamp(line_i.y_start);
  assign xe    = clamp(line_i.x_end);
  assign ye    = clamp(line_i.y_end);
  assign adx   = (xe >= xs) ? (xe - xs) : (xs - xe);
  assign ady   = (ye >= ys) ? (ye - ys) : (ys - ye);
  assign steps = (adx > ady) ? adx : ady;

  // One divider, x increment first, then y
  assign div_load     = (accept && (steps != '0)) || (state_q == S_DIVX && div_done);
  assign div_dividend = accept ? adx : ady_q;
  assign quot_pos     = {1'b0, div_quot};

  dlr_divider #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .dividend_i (div_dividend),
    .divisor_i  (accept ? steps : steps_total_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Accumulators carry a pre-added half, so rounding is just truncation
  assign x_sum      = x_acc_q + {{(ACC_W-STEP_W){x_step_q[STEP_W-1]}}, x_step_q};
  assign y_sum      = y_acc_q + {{(ACC_W-STEP_W){y_step_q[STEP_W-1]}}, y_step_q};
  assign steps_next = steps_done_q + 1'b1;

  always_comb begin
    state_d       = state_q;
    strobe_d      = 1'b0;
    out_d         = out_q;
    steps_total_d = steps_total_q;
    steps_done_d  = steps_done_q;
    ady_d         = ady_q;
    x_neg_d       = x_neg_q;
    y_neg_d       = y_neg_q;
    x_step_d      = x_step_q;
    y_step_d      = y_step_q;
    x_acc_d       = x_acc_q;
    y_acc_d       = y_acc_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // start pixel goes out right away
          strobe_d         = 1'b1;
          out_d.pixel_x    = xs;
          out_d.pixel_y    = ys;
          out_d.color      = color_q;
          out_d.last_pixel = (steps == '0);
          steps_total_d    = steps;
          steps_done_d     = '0;
          ady_d            = ady;
          x_neg_d          = (xe < xs);
          y_neg_d          = (ye < ys);
          x_step_d         = '0;
          y_step_d         = '0;
          x_acc_d          = {2'b00, xs, 1'b1, {(FRACTION_BITS-1){1'b0}}};
          y_acc_d          = {2'b00, ys, 1'b1, {(FRACTION_BITS-1){1'b0}}};
          if (steps != '0) begin
            state_d = S_DIVX;
          end
        end
      end
      S_DIVX: begin
        if (div_done) begin
          x_step_d = x_neg_q ? (STEP_W'(0) - quot_pos) : quot_pos;
          state_d  = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          y_step_d = y_neg_q ? (STEP_W'(0) - quot_pos) : quot_pos;
          state_d  = S_WALK;
        end
      end
      S_WALK: begin
        x_acc_d          = x_sum;
        y_acc_d          = y_sum;
        steps_done_d     = steps_next;
        strobe_d         = 1'b1;
        // a negative position saturates to column or row zero
        out_d.pixel_x    = x_sum[ACC_W-1] ? '0
                         : x_sum[FRACTION_BITS+COORD_W-1:FRACTION_BITS];
        out_d.pixel_y    = y_sum[ACC_W-1] ? '0
                         : y_sum[FRACTION_BITS+COORD_W-1:FRACTION_BITS];
        out_d.color      = color_q;
        out_d.last_pixel = (steps_next == steps_total_q);
        if (steps_next == steps_total_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
      color_q  <= COLOR_RESET;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q         <= out_d;
    steps_total_q <= steps_total_d;
    steps_done_q  <= steps_done_d;
    ady_q         <= ady_d;
    x_neg_q       <= x_neg_d;
    y_neg_q       <= y_neg_d;
    x_step_q      <= x_step_d;
    y_step_q      <= y_step_d;
    x_acc_q       <= x_acc_d;
    y_acc_q       <= y_acc_d;
  end

  assign pixel_strobe_o = strobe_q;
  assign pixel_o        = out_q;

endmodule

`default_nettype wire

// ----- src/dlr_checker.sv -----
// dlr_checker: port-level assertions for the DDA line rasterizer, bound to the top.
// Depends on dlr_pkg.
`default_nettype none

module dlr_checker
  import dlr_pkg::*;
(
  input wire         clk_i,
  input wire         rst_ni,
  input wire         start,
  input wire         busy,
  input wire         pixel_strobe_o,
  input wire pixel_t pixel_o
);

  // every accepted line shows its start pixel on the next cycle
  a_start_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> pixel_strobe_o)
    else $error("no start pixel after line transaction");

  // the final pixel coincides with the block going idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_strobe_o && pixel_o.last_pixel) |-> !busy)
    else $error("busy still high on last pixel");

  // more pixels pending keeps the block busy
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_strobe_o && !pixel_o.last_pixel) |-> busy)
    else $error("idle before last pixel");

  // leaving busy is always marked by the last pixel
  a_fall_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (pixel_strobe_o && pixel_o.last_pixel))
    else $error("busy dropped without last pixel");

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .pixel_strobe_o (pixel_strobe_o),
  .pixel_o        (pixel_o)
);

`default_nettype wire

// ----- tb/dda_line_rasterizer_tb.sv -----
// dda_line_rasterizer_tb: self-checking testbench for the DDA line rasterizer.
// Depends on dlr_pkg and the dda_line_rasterizer RTL; needs nothing else.
// Lines and colour writes go to the block; every pixel is checked against a local DDA model.
`timescale 1ns / 1ps

module dda_line_rasterizer_tb;
  import dlr_pkg::*;

  localparam int FRAC_BITS     = 16;
  localparam int N_RANDOM      = 151;
  // idle cycles demanded before a colour write; the last pixel marks the end
  // of the walk, so a handful of cycles is plenty
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 40;
  // bound for the slowest run: ~170 lines, each a gap, the divides and its pixels
  localparam int CYCLE_LIMIT   = 300000;

  // one entry of the stimulus queue: a line to draw or a new pixel colour
  typedef enum logic {
    JOB_LINE,
    JOB_COLOR
  } job_kind_e;

  typedef struct {
    job_kind_e          kind;
    line_t              ln;
    logic [COLOR_W-1:0] col;
  } job_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  line_t              line_i = '0;
  logic               pixel_strobe_o;
  pixel_t             pixel_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [COLOR_W-1:0] cfg_data_i = '0;

  job_t   job_q[$];
  pixel_t pixel_expect_q[$];
  int     errors = 0;
  int     cycle_cnt = 0;

  dda_line_rasterizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .line_i         (line_i),
    .pixel_strobe_o (pixel_strobe_o),
    .pixel_o        (pixel_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ------------------------------------------------------------------
  // Pixel model
  // ------------------------------------------------------------------

  // add one half, drop the fraction, floor at zero
  function automatic logic [COORD_W-1:0] round_coord(longint acc);
    longint v;
    v = acc + (longint'(1) <<< (FRAC_BITS - 1));
    if (v < 0) v = 0;
    return COORD_W'(v >>> FRAC_BITS);
  endfunction

  // Queues every pixel one line produces: start pixel, then one per step.
  // Increments are truncated toward zero before the sign is applied.
  function automatic void rasterize_line(line_t ln, logic [COLOR_W-1:0] col);
    int     xs, ys, xe, ye, adx, ady, steps, k;
    longint xacc, yacc, xinc, yinc;
    pixel_t px;
    xs    = ln.x_start;
    ys    = ln.y_start;
    xe    = ln.x_end;
    ye    = ln.y_end;
    adx   = (xs > xe) ? xs - xe : xe - xs;
    ady   = (ys > ye) ? ys - ye : ye - ys;
    steps = (adx > ady) ? adx : ady;
    xacc  = longint'(xs) <<< FRAC_BITS;
    yacc  = longint'(ys) <<< FRAC_BITS;
    xinc  = 0;
    yinc  = 0;
    if (steps != 0) begin
      xinc = (longint'(adx) <<< FRAC_BITS) / steps;
      yinc = (longint'(ady) <<< FRAC_BITS) / steps;
      if (xe < xs) xinc = -xinc;
      if (ye < ys) yinc = -yinc;
    end
    px.pixel_x    = COORD_W'(xs);
    px.pixel_y    = COORD_W'(ys);
    px.color      = col;
    px.last_pixel = (steps == 0);
    pixel_expect_q.push_back(px);
    for (k = 1; k <= steps; k++) begin
      xacc += xinc;
      yacc += yinc;
      px.pixel_x    = round_coord(xacc);
      px.pixel_y    = round_coord(yacc);
      px.last_pixel = (k == steps);
      pixel_expect_q.push_back(px);
    end
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  function automatic void add_line(int xs, int ys, int xe, int ye);
    job_t j;
    j.kind = JOB_LINE;
    j.ln   = '{x_start: COORD_W'(xs), y_start: COORD_W'(ys),
               x_end: COORD_W'(xe), y_end: COORD_W'(ye)};
    j.col  = '0;
    job_q.push_back(j);
  endfunction

  function automatic void add_color(int c);
    job_t j;
    j.kind = JOB_COLOR;
    j.ln   = '0;
    j.col  = COLOR_W'(c);
    job_q.push_back(j);
  endfunction

  // a coordinate a few pixels away from c, kept inside the tile
  function automatic int near(int c);
    int v;
    v = c + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v;
  endfunction

  // ------------------------------------------------------------------
  // Driver: line transactions on start/busy, colour writes on cfg valid/ready.
  // All decisions are made on values sampled at the edge; each driven
  // signal gets exactly one nonblocking assignment per edge.
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : line_driver
    logic               nxt_start, nxt_cfg;
    line_t              nxt_line;
    logic [COLOR_W-1:0] nxt_col;
    logic [COLOR_W-1:0] color_now;
    int                 gap_left;
    int                 settle;
    logic               no_idle;
    job_t               j;
    if (!rst_ni) begin
      start       <= 1'b0;
      line_i      <= '0;
      cfg_valid_i <= 1'b0;
      cfg_data_i  <= '0;
      color_now   = COLOR_RESET;
      gap_left    = 0;
      settle      = 0;
      no_idle     = 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid_i;
      nxt_line  = line_i;
      nxt_col   = cfg_data_i;

      // line transaction completes: predict its pixels, draw the next gap
      if (start && !busy) begin
        rasterize_line(line_i, color_now);
        nxt_start = 1'b0;
        if ($urandom_range(0, 11) == 0) no_idle = ~no_idle;
        gap_left = no_idle ? 0 : $urandom_range(0, 7);
      end

      // colour write completes
      if (cfg_valid_i && cfg_ready_o) begin
        color_now = cfg_data_i;
        nxt_cfg   = 1'b0;
      end

      // block quiet: nothing in flight and nothing left to emit
      if (!busy && !nxt_start && pixel_expect_q.size() == 0) settle++;
      else settle = 0;

      if (!nxt_start && !nxt_cfg && job_q.size() > 0) begin
        if (job_q[0].kind == JOB_LINE) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            j         = job_q.pop_front();
            nxt_line  = j.ln;
            nxt_start = 1'b1;
          end
        end else if (settle > SETTLE_CYCLES) begin
          // registers only change with the block idle
          j       = job_q.pop_front();
          nxt_col = j.col;
          nxt_cfg = 1'b1;
        end
      end

      start       <= nxt_start;
      line_i      <= nxt_line;
      cfg_valid_i <= nxt_cfg;
      cfg_data_i  <= nxt_col;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: each strobed pixel against the oldest expected one
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : pixel_monitor
    pixel_t exp_px;
    if (rst_ni && pixel_strobe_o === 1'b1) begin
      if (pixel_expect_q.size() == 0) begin
        $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0b", $time,
                 pixel_o.pixel_x, pixel_o.pixel_y, pixel_o.color, pixel_o.last_pixel);
        errors++;
      end else begin
        exp_px = pixel_expect_q.pop_front();
        if (pixel_o.pixel_x !== exp_px.pixel_x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time,
                   exp_px.pixel_x, pixel_o.pixel_x);
          errors++;
        end
        if (pixel_o.pixel_y !== exp_px.pixel_y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time,
                   exp_px.pixel_y, pixel_o.pixel_y);
          errors++;
        end
        if (pixel_o.color !== exp_px.color) begin
          $display("%0t: color expected %0d actual %0d", $time,
                   exp_px.color, pixel_o.color);
          errors++;
        end
        if (pixel_o.last_pixel !== exp_px.last_pixel) begin
          $display("%0t: last_pixel expected %0b actual %0b", $time,
                   exp_px.last_pixel, pixel_o.last_pixel);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_cnt,
               pixel_expect_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus and end of run
  // ------------------------------------------------------------------
  initial begin : stimulus
    int i, r, xs, ys, xe, ye;

    // directed, reset colour: zero-length lines at both corners, full axes
    add_line(0, 0, 0, 0);
    add_line(63, 63, 63, 63);
    add_line(0, 0, 63, 0);
    add_line(63, 5, 0, 5);
    add_line(7, 0, 7, 63);
    add_line(40, 63, 40, 0);
    // colour 0: diagonals and the steepest and flattest slopes
    add_color(0);
    add_line(0, 0, 63, 63);
    add_line(63, 0, 0, 63);
    add_line(63, 63, 0, 0);
    add_line(0, 0, 63, 1);
    add_line(0, 0, 1, 63);
    add_line(62, 63, 0, 62);
    // colour 15: single steps and half-pixel ties under truncated increments
    add_color(15);
    add_line(5, 5, 6, 5);
    add_line(5, 5, 4, 4);
    add_line(0, 0, 12, 5);
    add_line(63, 63, 51, 58);
    add_line(0, 0, 62, 31);
    add_line(10, 20, 13, 50);
    add_line(21, 42, 42, 21);

    // random lines, a new colour every few dozen
    for (i = 0; i < N_RANDOM; i++) begin
      if (i % 34 == 0) add_color($urandom_range(0, 15));
      xs = $urandom_range(0, 63);
      ys = $urandom_range(0, 63);
      xe = $urandom_range(0, 63);
      ye = $urandom_range(0, 63);
      r  = $urandom_range(0, 9);
      if (r == 6 || r == 7) begin
        xe = near(xs);
        ye = near(ys);
      end else if (r == 8) begin
        xe = xs;
        ye = ys;
      end else if (r == 9) begin
        if ($urandom_range(0, 1) == 1) xe = xs;
        else ye = ys;
      end
      add_line(xs, ys, xe, ye);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample between edges so the driver's updates have settled
    do @(negedge clk_i);
    while (job_q.size() != 0 || start || cfg_valid_i || pixel_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/dlr_pkg.sv
src/dlr_divider.sv
src/dda_line_rasterizer.sv
src/dlr_checker.sv
tb/dda_line_rasterizer_tb.sv
